// File: rtl/lz4_block_decompressor_macros.svh
// Assertion macros for the LZ4 block decompressor.
`ifndef LZ4_BLOCK_DECOMPRESSOR_MACROS_SVH
`define LZ4_BLOCK_DECOMPRESSOR_MACROS_SVH

// Check that holds on every clock edge out of reset.
`define LZ4BD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an implication holds on every clock edge out of reset.
`define LZ4BD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/lz4bd_pkg.sv
// Types and constants shared by the LZ4 block decompressor.
package lz4bd_pkg;

  localparam int unsigned HIST_AW  = 16;
  localparam int unsigned HIST_DEPTH = 1 << HIST_AW;
  localparam int unsigned LEN_W    = 23;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [LEN_W-1:0] CAP_RESET = 23'd65536;

  typedef enum logic [1:0] {
    MODE_COMP = 2'd0,
    MODE_DICT = 2'd1,
    MODE_TICK = 2'd2,
    MODE_TICK_ALT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_RUN       = 3'd0,
    ST_DONE      = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_ZERO_OFF  = 3'd3,
    ST_FAR_OFF   = 3'd4,
    ST_CAPACITY  = 3'd5,
    ST_OVERRUN   = 3'd6,
    ST_DISCARD   = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LIT_EXT, PH_LITERAL, PH_OFF_LO,
    PH_OFF_HI, PH_MATCH_EXT, PH_PENDING, PH_DISCARD
  } phase_t;

  // One queued job for the history side: memory op plus the result fields.
  typedef struct packed {
    logic              wr;
    logic              cp;
    logic [HIST_AW-1:0] waddr;
    logic [HIST_AW-1:0] raddr;
    logic [7:0]        data;
    logic              out_valid;
    logic              match_end;
    status_t           status;
    logic [LEN_W-1:0]  out_count;
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic [1:0] level;
  } q_stat_t;

endpackage

// File: rtl/lz4bd_in_if.sv
// Input channel: compressed bytes, dictionary bytes and drain ticks.
interface lz4bd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] in_byte;
  logic       block_end;

  modport source (output valid, mode, in_byte, block_end, input ready);
  modport sink (input valid, mode, in_byte, block_end, output ready);
endinterface

// File: rtl/lz4bd_out_if.sv
// Result channel: one result per accepted input item.
interface lz4bd_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        match_end;
  logic [2:0]  status;
  logic [22:0] out_count;

  modport source (output valid, out_valid, out_byte, match_end, status, out_count,
                  input ready);
  modport sink (input valid, out_valid, out_byte, match_end, status, out_count,
                output ready);
endinterface

// File: rtl/lz4bd_front.sv
// Parser: takes input items, tracks block state and issues history jobs.
module lz4bd_front #(
  parameter int unsigned MAX_BLOCK_BYTES = 4194304
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [1:0]            mode,
  input  logic [7:0]            in_byte,
  input  logic                  block_end,
  input  logic                  cfg_we,
  input  logic [22:0]           cfg_wdata,
  output lz4bd_pkg::cmd_t       cmd
);
  import lz4bd_pkg::*;

  localparam logic [LEN_W:0] MAX_B = (LEN_W+1)'(MAX_BLOCK_BYTES);

  phase_t            phase_r, phase_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt, off_r, off_nxt;
  logic [HIST_AW:0]  fill_r, fill_nxt;
  logic [LEN_W-1:0]  prod_r, prod_nxt, len_r, len_nxt, rem_r, rem_nxt, cap_r;
  logic [3:0]        nib_r, nib_nxt;
  logic              eam_r, eam_nxt;
  logic [LEN_W:0]    cap_eff;
  logic [LEN_W:0]    sum;
  logic [LEN_W-1:0]  sat;
  logic [HIST_AW-1:0] off_full;
  logic              do_fail, do_clr, do_push;
  status_t           fcode;

  function automatic logic fits(input logic [LEN_W-1:0] p, input logic [LEN_W-1:0] n,
                                input logic [LEN_W:0] c);
    logic [LEN_W:0] s;
    s = {1'b0, p} + {1'b0, n};
    return s <= c;
  endfunction

  assign cap_eff = ({1'b0, cap_r} > MAX_B) ? MAX_B : {1'b0, cap_r};
  assign sum     = {1'b0, len_r} + {{LEN_W-7{1'b0}}, in_byte};
  assign sat     = sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
  assign off_full = {in_byte, off_r[7:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOKEN;
      wp_r    <= '0;
      fill_r  <= '0;
      prod_r  <= '0;
      len_r   <= '0;
      nib_r   <= '0;
      off_r   <= '0;
      rem_r   <= '0;
      eam_r   <= 1'b0;
      cap_r   <= CAP_RESET;
    end else begin
      phase_r <= phase_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      prod_r  <= prod_nxt;
      len_r   <= len_nxt;
      nib_r   <= nib_nxt;
      off_r   <= off_nxt;
      rem_r   <= rem_nxt;
      eam_r   <= eam_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    prod_nxt  = prod_r;
    len_nxt   = len_r;
    nib_nxt   = nib_r;
    off_nxt   = off_r;
    rem_nxt   = rem_r;
    eam_nxt   = eam_r;
    cmd       = '0;
    cmd.status = ST_RUN;
    do_fail   = 1'b0;
    do_clr    = 1'b0;
    do_push   = 1'b0;
    fcode     = ST_RUN;
    cmd.waddr = wp_r;
    cmd.raddr = wp_r - off_r;
    cmd.data  = in_byte;

    if (acc) begin
      if (mode_t'(mode) == MODE_DICT) begin
        if (phase_r == PH_TOKEN && prod_r == '0) begin
          do_push = 1'b1;
        end else if (phase_r == PH_DISCARD) begin
          cmd.status = ST_DISCARD;
        end
      end else if (mode[1]) begin
        if (phase_r == PH_PENDING) begin
          do_push = 1'b1;
          cmd.cp = 1'b1;
          cmd.out_valid = 1'b1;
          prod_nxt = prod_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
          if (rem_r == LEN_W'(1)) begin
            cmd.match_end = 1'b1;
            if (eam_r) begin
              cmd.out_count = prod_r + 1'b1;
              cmd.status = ST_DONE;
              do_clr = 1'b1;
            end else begin
              phase_nxt = PH_TOKEN;
            end
          end
        end else if (phase_r == PH_DISCARD) begin
          cmd.status = ST_DISCARD;
        end
      end else begin
        unique case (phase_r)
          PH_TOKEN: begin
            len_nxt = LEN_W'(in_byte[7:4]);
            nib_nxt = in_byte[3:0];
            if (in_byte[7:4] == 4'hF) begin
              if (block_end) begin
                do_fail = 1'b1; fcode = ST_TRUNC;
              end else begin
                phase_nxt = PH_LIT_EXT;
              end
            end else if (in_byte[7:4] != 4'h0) begin
              if (!fits(prod_r, LEN_W'(in_byte[7:4]), cap_eff)) begin
                do_fail = 1'b1; fcode = ST_CAPACITY;
              end else if (block_end) begin
                do_fail = 1'b1; fcode = ST_TRUNC;
              end else begin
                phase_nxt = PH_LITERAL;
              end
            end else if (block_end) begin
              cmd.out_count = prod_r;
              cmd.status = ST_DONE;
              do_clr = 1'b1;
            end else begin
              phase_nxt = PH_OFF_LO;
            end
          end
          PH_LIT_EXT: begin
            len_nxt = sat;
            if (in_byte == 8'hFF) begin
              if (block_end) begin
                do_fail = 1'b1; fcode = ST_TRUNC;
              end
            end else if (!fits(prod_r, sat, cap_eff)) begin
              do_fail = 1'b1; fcode = ST_CAPACITY;
            end else if (block_end) begin
              do_fail = 1'b1; fcode = ST_TRUNC;
            end else begin
              phase_nxt = PH_LITERAL;
            end
          end
          PH_LITERAL: begin
            if (block_end && len_r > LEN_W'(1)) begin
              do_fail = 1'b1; fcode = ST_TRUNC;
            end else begin
              do_push = 1'b1;
              cmd.out_valid = 1'b1;
              prod_nxt = prod_r + 1'b1;
              len_nxt  = len_r - 1'b1;
              if (len_r == LEN_W'(1)) begin
                if (block_end) begin
                  cmd.out_count = prod_r + 1'b1;
                  cmd.status = ST_DONE;
                  do_clr = 1'b1;
                end else begin
                  phase_nxt = PH_OFF_LO;
                end
              end
            end
          end
          PH_OFF_LO: begin
            off_nxt = HIST_AW'(in_byte);
            if (block_end) begin
              do_fail = 1'b1; fcode = ST_TRUNC;
            end else begin
              phase_nxt = PH_OFF_HI;
            end
          end
          PH_OFF_HI: begin
            off_nxt = off_full;
            if (off_full == '0) begin
              do_fail = 1'b1; fcode = ST_ZERO_OFF;
            end else if ({1'b0, off_full} > fill_r) begin
              do_fail = 1'b1; fcode = ST_FAR_OFF;
            end else if (nib_r == 4'hF) begin
              len_nxt = LEN_W'(19);
              if (block_end) begin
                do_fail = 1'b1; fcode = ST_TRUNC;
              end else begin
                phase_nxt = PH_MATCH_EXT;
              end
            end else if (!fits(prod_r, LEN_W'(nib_r) + LEN_W'(4), cap_eff)) begin
              do_fail = 1'b1; fcode = ST_CAPACITY;
            end else begin
              rem_nxt = LEN_W'(nib_r) + LEN_W'(4);
              eam_nxt = block_end;
              phase_nxt = PH_PENDING;
            end
          end
          PH_MATCH_EXT: begin
            len_nxt = sat;
            if (in_byte == 8'hFF) begin
              if (block_end) begin
                do_fail = 1'b1; fcode = ST_TRUNC;
              end
            end else if (!fits(prod_r, sat, cap_eff)) begin
              do_fail = 1'b1; fcode = ST_CAPACITY;
            end else begin
              rem_nxt = sat;
              eam_nxt = block_end;
              phase_nxt = PH_PENDING;
            end
          end
          PH_PENDING: begin
            do_fail = 1'b1; fcode = ST_OVERRUN;
          end
          PH_DISCARD: begin
            cmd.status = ST_DISCARD;
            do_clr = block_end;
          end
          default: ;
        endcase
      end

      if (do_push) begin
        cmd.wr = 1'b1;
        wp_nxt = wp_r + 1'b1;
        if (!fill_r[HIST_AW]) begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      if (do_fail) begin
        cmd.status = fcode;
        if (block_end) begin
          do_clr = 1'b1;
        end else begin
          phase_nxt = PH_DISCARD;
        end
      end
      if (do_clr) begin
        phase_nxt = PH_TOKEN;
        wp_nxt    = '0;
        fill_nxt  = '0;
        prod_nxt  = '0;
        len_nxt   = '0;
        nib_nxt   = '0;
        off_nxt   = '0;
        rem_nxt   = '0;
        eam_nxt   = 1'b0;
      end
    end
  end
endmodule

// File: rtl/lz4bd_queue.sv
// Two-entry job queue between parser and history side.
module lz4bd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lz4bd_pkg::cmd_t     push_cmd,
  input  logic                pop,
  output logic                head_vld,
  output lz4bd_pkg::cmd_t     head_cmd,
  output lz4bd_pkg::q_stat_t  stat
);
  import lz4bd_pkg::*;

  cmd_t       ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign head_vld   = cnt_r != 2'd0;
  assign head_cmd   = ent_r[rptr_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.level = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/lz4bd_back.sv
// History side: 64 KiB history memory, copy path with bypass, result register.
module lz4bd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_vld,
  input  lz4bd_pkg::cmd_t  head_cmd,
  output logic             pop,
  lz4bd_out_if.source      out_if
);
  import lz4bd_pkg::*;

  logic [7:0]  mem [HIST_DEPTH];
  cmd_t        b_cmd_r;
  logic        b_vld_r;
  logic [7:0]  b_rd_r;
  logic        b_byp_r;
  logic [7:0]  b_bypd_r;
  logic [7:0]  b_byte;
  logic        b_go;
  logic        o_vld_r;
  logic        o_ov_r, o_mend_r;
  logic [7:0]  o_byte_r;
  logic [2:0]  o_st_r;
  logic [22:0] o_cnt_r;

  assign b_byte = !b_cmd_r.cp ? b_cmd_r.data : (b_byp_r ? b_bypd_r : b_rd_r);
  assign b_go   = b_vld_r && (!o_vld_r || out_if.ready);
  assign pop    = head_vld && (!b_vld_r || b_go);

  always_ff @(posedge clk) begin
    if (b_go && b_cmd_r.wr) begin
      mem[b_cmd_r.waddr] <= b_byte;
    end
    if (pop) begin
      b_rd_r <= mem[head_cmd.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_cmd_r <= head_cmd;
      // the job ahead writes this cycle: read would miss it
      b_byp_r  <= b_go && b_cmd_r.wr && (b_cmd_r.waddr == head_cmd.raddr);
      b_bypd_r <= b_byte;
    end
    if (b_go) begin
      o_ov_r   <= b_cmd_r.out_valid;
      o_byte_r <= b_cmd_r.out_valid ? b_byte : 8'h00;
      o_mend_r <= b_cmd_r.match_end;
      o_st_r   <= b_cmd_r.status;
      o_cnt_r  <= b_cmd_r.out_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        b_vld_r <= 1'b1;
      end else if (b_go) begin
        b_vld_r <= 1'b0;
      end
      if (b_go) begin
        o_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        o_vld_r <= 1'b0;
      end
    end
  end

  assign out_if.valid     = o_vld_r;
  assign out_if.out_valid = o_ov_r;
  assign out_if.out_byte  = o_byte_r;
  assign out_if.match_end = o_mend_r;
  assign out_if.status    = o_st_r;
  assign out_if.out_count = o_cnt_r;
endmodule

// File: rtl/lz4_block_decompressor.sv
// LZ4 block decompressor with dictionary preload: top level.
//
// in_if carries one item per transfer: a compressed byte (mode 0), a
// dictionary byte (mode 1) or a drain tick (mode 2 or 3). Every accepted
// item yields exactly one result on out_if, in order, carrying a literal
// or copied byte when out_valid is set, plus status and the byte count.
// A match is copied one byte per drain tick from the 64 KiB history.
// cfg_we/cfg_wdata write out_capacity; write only while the block is idle.
// Throughput is one item per cycle while out_if keeps up; the parser decides
// each item in the cycle it is accepted, the history RAM has one write and one read port.
// With no stall, a result is valid once its item has passed the job queue
// (written on the transfer edge), the RAM read stage and the result register.
// When the receiver stalls, results back up into the two-entry job queue
// and in_if.ready drops once it is full; nothing is lost.
// Reset (synchronous, rst_n low) clears the parser, counts and queues and
// sets out_capacity to 65536; history contents are left as they are.
module lz4_block_decompressor #(
  parameter int unsigned MAX_BLOCK_BYTES = 4194304
) (
  input  logic         clk,
  input  logic         rst_n,
  lz4bd_in_if.sink     in_if,
  lz4bd_out_if.source  out_if,
  input  logic         cfg_we,
  input  logic [22:0]  cfg_wdata
);
  import lz4bd_pkg::*;
  `include "lz4_block_decompressor_macros.svh"

  logic     acc, pop, head_vld;
  cmd_t     cmd, head_cmd;
  q_stat_t  q_stat;

  assign in_if.ready = !q_stat.full;
  assign acc = in_if.valid && in_if.ready;

  lz4bd_front #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)) u_front (
    .clk, .rst_n, .acc,
    .mode(in_if.mode), .in_byte(in_if.in_byte), .block_end(in_if.block_end),
    .cfg_we, .cfg_wdata, .cmd
  );

  lz4bd_queue u_queue (
    .clk, .rst_n, .push(acc), .push_cmd(cmd), .pop,
    .head_vld, .head_cmd, .stat(q_stat)
  );

  lz4bd_back u_back (
    .clk, .rst_n, .head_vld, .head_cmd, .pop, .out_if
  );

  `LZ4BD_ASSERT_IMP(a_no_q_overflow, acc, q_stat.level != 2'd2, "job queue overflow")
  `LZ4BD_ASSERT_IMP(a_no_q_underflow, pop, q_stat.level != 2'd0, "pop from empty queue")
  `LZ4BD_ASSERT_IMP(a_byte_status, out_if.valid && out_if.out_valid,
    out_if.status == ST_RUN || out_if.status == ST_DONE, "data byte with error status")
  `LZ4BD_ASSERT(a_done_only_on_end,
    !(acc && cmd.status == ST_DONE && !in_if.block_end && !cmd.cp), "done without block end")
endmodule

// File: bench/tb_lz4_block_decompressor.sv
// Self-checking testbench for the LZ4 block decompressor.
`timescale 1ns / 100ps

import lz4bd_pkg::*;

typedef struct packed {
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        match_end;
  logic [2:0]  status;
  logic [22:0] out_count;
} lz4_res_t;

class lz4_scoreboard;
  bit [7:0]    hist [HIST_DEPTH];
  bit [15:0]   wr_ptr;
  int unsigned fill;
  int unsigned produced;
  int unsigned cap;
  phase_t      ph;
  bit [22:0]   len_acc;
  bit [3:0]    nib;
  int unsigned offset;
  bit [22:0]   remaining;
  bit          end_after;
  lz4_res_t    pending_q [$];
  int unsigned errors;
  int unsigned checked;

  function void init();
    cap = CAP_RESET;
    errors = 0;
    checked = 0;
    clear_blk();
  endfunction

  function void clear_blk();
    wr_ptr = '0;
    fill = 0;
    produced = 0;
    ph = PH_TOKEN;
    len_acc = '0;
    nib = '0;
    offset = 0;
    remaining = '0;
    end_after = 1'b0;
  endfunction

  function void hist_push(bit [7:0] b);
    hist[wr_ptr] = b;
    wr_ptr = wr_ptr + 16'd1;
    if (fill < HIST_DEPTH) fill++;
  endfunction

  function bit fits(longint unsigned n);
    longint unsigned lim;
    lim = (cap > 4194304) ? 4194304 : cap;
    return (produced + n) <= lim;
  endfunction

  function bit [22:0] sat_add(bit [22:0] a, bit [7:0] b);
    int unsigned s;
    s = a + b;
    return (s > LEN_MAX) ? LEN_MAX : s[22:0];
  endfunction

  function status_t fail(status_t code, bit last);
    if (last) clear_blk();
    else ph = PH_DISCARD;
    return code;
  endfunction

  function status_t begin_lits(bit last);
    if (!fits(len_acc)) return fail(ST_CAPACITY, last);
    if (last) return fail(ST_TRUNC, last);
    ph = PH_LITERAL;
    return ST_RUN;
  endfunction

  function status_t begin_match(bit [22:0] n, bit last);
    if (!fits(n)) return fail(ST_CAPACITY, last);
    remaining = n;
    end_after = last;
    ph = PH_PENDING;
    return ST_RUN;
  endfunction

  // Work out the result of one accepted item and queue it.
  function void note_input(bit [1:0] mode, bit [7:0] b, bit last);
    lz4_res_t r;
    status_t  st;
    st = ST_RUN;
    r = '0;
    if (mode == MODE_DICT) begin
      if (ph == PH_TOKEN && produced == 0) hist_push(b);
      else if (ph == PH_DISCARD) st = ST_DISCARD;
    end else if (mode != MODE_COMP) begin
      if (ph == PH_PENDING) begin
        r.out_byte = hist[wr_ptr - offset[15:0]];
        hist_push(r.out_byte);
        produced++;
        remaining--;
        r.out_valid = 1'b1;
        if (remaining == 0) begin
          r.match_end = 1'b1;
          if (end_after) begin
            r.out_count = 23'(produced);
            st = ST_DONE;
            clear_blk();
          end else begin
            ph = PH_TOKEN;
          end
        end
      end else if (ph == PH_DISCARD) begin
        st = ST_DISCARD;
      end
    end else begin
      case (ph)
        PH_TOKEN: begin
          len_acc = b[7:4];
          nib = b[3:0];
          if (len_acc == 15) begin
            if (last) st = fail(ST_TRUNC, last);
            else ph = PH_LIT_EXT;
          end else if (len_acc > 0) begin
            st = begin_lits(last);
          end else if (last) begin
            r.out_count = 23'(produced);
            st = ST_DONE;
            clear_blk();
          end else begin
            ph = PH_OFF_LO;
          end
        end
        PH_LIT_EXT: begin
          len_acc = sat_add(len_acc, b);
          if (b == 8'hFF) begin
            if (last) st = fail(ST_TRUNC, last);
          end else begin
            st = begin_lits(last);
          end
        end
        PH_LITERAL: begin
          if (last && len_acc > 1) begin
            st = fail(ST_TRUNC, last);
          end else begin
            hist_push(b);
            produced++;
            len_acc--;
            r.out_valid = 1'b1;
            r.out_byte = b;
            if (len_acc == 0) begin
              if (last) begin
                r.out_count = 23'(produced);
                st = ST_DONE;
                clear_blk();
              end else begin
                ph = PH_OFF_LO;
              end
            end
          end
        end
        PH_OFF_LO: begin
          offset = b;
          if (last) st = fail(ST_TRUNC, last);
          else ph = PH_OFF_HI;
        end
        PH_OFF_HI: begin
          offset = offset | (int'(b) << 8);
          if (offset == 0) st = fail(ST_ZERO_OFF, last);
          else if (offset > fill) st = fail(ST_FAR_OFF, last);
          else if (nib == 15) begin
            len_acc = 23'd19;
            if (last) st = fail(ST_TRUNC, last);
            else ph = PH_MATCH_EXT;
          end else begin
            st = begin_match(nib + 23'd4, last);
          end
        end
        PH_MATCH_EXT: begin
          len_acc = sat_add(len_acc, b);
          if (b == 8'hFF) begin
            if (last) st = fail(ST_TRUNC, last);
          end else begin
            st = begin_match(len_acc, last);
          end
        end
        PH_PENDING: st = fail(ST_OVERRUN, last);
        default: begin
          st = ST_DISCARD;
          if (last) clear_blk();
        end
      endcase
    end
    r.status = st;
    pending_q.push_back(r);
  endfunction

  function void check(lz4_res_t got);
    lz4_res_t exp_r;
    checked++;
    if (pending_q.size() == 0) begin
      $error("result with nothing expected: %p", got);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.out_valid !== exp_r.out_valid) begin
      $error("out_valid exp %0d got %0d", exp_r.out_valid, got.out_valid);
      errors++;
    end
    if (got.out_byte !== exp_r.out_byte) begin
      $error("out_byte exp %0h got %0h", exp_r.out_byte, got.out_byte);
      errors++;
    end
    if (got.match_end !== exp_r.match_end) begin
      $error("match_end exp %0d got %0d", exp_r.match_end, got.match_end);
      errors++;
    end
    if (got.status !== exp_r.status) begin
      $error("status exp %0d got %0d", exp_r.status, got.status);
      errors++;
    end
    if (got.out_count !== exp_r.out_count) begin
      $error("out_count exp %0d got %0d", exp_r.out_count, got.out_count);
      errors++;
    end
  endfunction
endclass

module tb_lz4_block_decompressor;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [22:0] cfg_wdata;

  lz4bd_in_if  in_ch();
  lz4bd_out_if out_ch();

  lz4_block_decompressor uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  lz4_scoreboard sb;
  int unsigned   items_sent;
  int unsigned   blocks_sent;
  int unsigned   idle_cycles;
  bit            held_once;
  int unsigned   hold_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random back-pressure, plus one long hold-off once traffic is flowing.
  initial begin
    out_ch.ready = 1'b0;
    held_once = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (!held_once && items_sent >= 300) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if ((items_sent / 200) % 3 == 0) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) < 75) ||
                       ($urandom_range(99) < 3 ? 1'b0 : 1'b0);
        if ($urandom_range(199) == 0) begin
          out_ch.ready = 1'b0;
          repeat ($urandom_range(40, 15)) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check({out_ch.out_valid, out_ch.out_byte, out_ch.match_end,
                out_ch.status, out_ch.out_count});
  end

  // Watchdog: cycles with no transfer on either channel while work is outstanding.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (in_ch.valid || sb.pending_q.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(bit [1:0] mode, bit [7:0] b, bit last);
    int unsigned gap;
    int unsigned pick;
    pick = $urandom_range(99);
    if ((items_sent / 250) % 4 == 1) gap = 0;
    else if (pick < 70) gap = 0;
    else if (pick < 96) gap = $urandom_range(3, 1);
    else gap = $urandom_range(40, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode = mode;
    in_ch.in_byte = b;
    in_ch.block_end = last;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(mode, b, last);
    items_sent++;
  endtask

  task automatic comp(bit [7:0] b, bit last = 1'b0);
    send(MODE_COMP, b, last);
  endtask

  task automatic tick();
    send($urandom_range(9) == 0 ? MODE_TICK_ALT : MODE_TICK, $urandom_range(255), 1'b0);
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_capacity(int unsigned v);
    quiesce();
    cfg_wdata = v[22:0];
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.cap = v;
  endtask

  // Bring the parser back to a clean token state with empty history.
  task automatic resync();
    while (!(sb.ph == PH_TOKEN && sb.produced == 0 && sb.fill == 0)) begin
      if (sb.ph == PH_PENDING) tick();
      else comp(8'h00, 1'b1);
    end
  endtask

  task automatic send_len_ext(int unsigned extra, bit last);
    while (extra >= 255) begin
      comp(8'hFF);
      extra -= 255;
    end
    comp(extra[7:0], last);
  endtask

  // One well-formed block built from the predictor's view of history.
  task automatic gen_block(int unsigned nseq, bit end_on_match);
    int unsigned lit;
    int unsigned mlen;
    int unsigned off;
    int unsigned lim;
    bit          last_seq;
    repeat ($urandom_range(99) < 60 ? $urandom_range(24) : 0)
      send(MODE_DICT, $urandom_range(255), $urandom_range(1));
    for (int unsigned s = 0; s < nseq; s++) begin
      last_seq = (s == nseq - 1);
      lit = ($urandom_range(9) < 7) ? $urandom_range(6) : $urandom_range(40, 7);
      if (last_seq && !end_on_match) begin
        comp({lit >= 15 ? 4'hF : lit[3:0], 4'($urandom_range(15))}, lit == 0);
        if (lit >= 15) send_len_ext(lit - 15, 1'b0);
        for (int unsigned i = 0; i < lit; i++) comp($urandom_range(255), i == lit - 1);
      end else begin
        if (sb.fill == 0 && lit == 0) lit = 1;
        mlen = ($urandom_range(9) < 7) ? $urandom_range(18, 4) : $urandom_range(60, 19);
        comp({lit >= 15 ? 4'hF : lit[3:0], mlen >= 19 ? 4'hF : 4'(mlen - 4)});
        if (lit >= 15) send_len_ext(lit - 15, 1'b0);
        for (int unsigned i = 0; i < lit; i++) comp($urandom_range(255));
        lim = (sb.fill == 0) ? 1 : (sb.fill > 65535 ? 65535 : sb.fill);
        off = ($urandom_range(3) == 0) ? lim : $urandom_range(lim < 8 ? lim : 8, 1);
        comp(off[7:0]);
        comp(off[15:8], last_seq && mlen < 19);
        if (mlen >= 19) send_len_ext(mlen - 19, last_seq);
        while (sb.ph == PH_PENDING) tick();
      end
    end
    blocks_sent++;
  endtask

  task automatic noise(int unsigned n);
    repeat (n) send($urandom_range(3), $urandom_range(255), $urandom_range(7) == 0);
    resync();
  endtask

  initial begin
    int unsigned pick;
    sb = new();
    sb.init();
    items_sent = 0;
    blocks_sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_COMP;
    in_ch.in_byte = '0;
    in_ch.block_end = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: dictionary, literal and an overlapping match that is never drained.
    send(MODE_DICT, 8'h00, 1'b0);
    send(MODE_DICT, 8'hFF, 1'b1);
    comp(8'h10); comp(8'hA5);
    comp(8'h01); comp(8'h00);
    send(MODE_DICT, 8'h5A, 1'b0);          // dictionary byte mid-block: ignored
    comp(8'h00, 1'b1);                      // overrun on block end clears
    tick();                                  // tick when idle
    comp(8'h00, 1'b1);                       // empty block
    comp(8'hF0, 1'b1);                       // truncated token
    comp(8'h10); comp(8'h11); comp(8'h00); comp(8'h00);  // zero offset
    tick(); comp(8'h33, 1'b1);               // discarding until end
    comp(8'h10); comp(8'h22); comp(8'h05); comp(8'h00, 1'b1);  // offset beyond history
    comp(8'h1F); comp(8'h7E); comp(8'h01); comp(8'h00); comp(8'h00, 1'b1);
    while (sb.ph == PH_PENDING) send(MODE_TICK_ALT, 8'hFF, 1'b1);
    set_capacity(1);
    comp(8'h20, 1'b1);                       // capacity before truncation
    resync();

    // Random blocks and noise bursts under a rotating output limit.
    while (items_sent < 1400) begin
      if (blocks_sent % 8 == 0) begin
        pick = $urandom_range(4);
        case (pick)
          0: set_capacity(1);
          1: set_capacity($urandom_range(120, 2));
          2: set_capacity(65536);
          3: set_capacity(4194304);
          default: set_capacity($urandom_range(4194304, 1));
        endcase
      end
      if ($urandom_range(9) == 0) noise($urandom_range(12, 1));
      else gen_block($urandom_range(6, 1), $urandom_range(1));
      resync();
    end

    quiesce();
    $display("%0d items in %0d generated blocks, %0d results checked",
             items_sent, blocks_sent, sb.checked);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
